@@ hw/rtl/erqt_pkg.sv @@
// Shared types and constants of the entity range query table.
`default_nettype none
package erqt_pkg;

    // Entity ids travel on 6 bits; at most 64 slots can ever be written.
    localparam int ID_W    = 6;
    localparam int ID_SPAN = 1 << ID_W;

    // Radius is unsigned Q15.8 on 23 bits; its square needs twice that.
    localparam int RAD_W = 23;
    localparam int RSQ_W = 2 * RAD_W;

    // Command codes; six and seven are unused and are dropped.
    typedef enum logic [2:0] {
        OP_INSERT  = 3'd0,
        OP_REMOVE  = 3'd1,
        OP_UPDATE  = 3'd2,
        OP_SPHERE  = 3'd3,
        OP_BOX     = 3'd4,
        OP_NEAREST = 3'd5
    } t_op;

    // Scan beat that walks down the compare pipeline with the table data.
    typedef struct packed {
        logic            v;    // beat present
        logic            fin;  // end-of-scan marker, carries no entry
        logic            ok;   // entry holds a live entity
        logic [ID_W-1:0] id;   // slot number of the entry
    } t_tok;

endpackage
`default_nettype wire

@@ hw/rtl/entity_range_query_table.sv @@
// Top level of the entity range query table.
// Keeps up to min(MAX_ENTITIES, 64) entity positions (signed Q15.8) in one
// RAM with a valid flag per slot in flip-flops, so reset empties the table at
// once. Insert, remove and update take one beat and produce no
// result; insert of a live id moves it, remove or update of an absent id is
// dropped. Sphere, box and nearest queries scan the RAM one entry per cycle
// while the result side takes beats, through its single read port, then let
// a four-stage compare pipeline drain; a query occupies the block until its
// end-of-scan beat leaves the pipeline. Sphere and box queries return every
// match in ascending id order with last on the final one; a nearest query
// returns the closest id in the radius, lowest id on a tie. A query without a
// match returns a single beat with hit clear, found_id zero and last set.
`default_nettype none
module entity_range_query_table #(
    parameter int MAX_ENTITIES = 64,
    parameter int COORD_BITS   = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [2:0]                   i_op,
    input  logic [5:0]                   i_entity_id,
    input  logic signed [COORD_BITS-1:0] i_pos_x,
    input  logic signed [COORD_BITS-1:0] i_pos_y,
    input  logic signed [COORD_BITS-1:0] i_pos_z,
    input  logic signed [COORD_BITS-1:0] i_box_max_x,
    input  logic signed [COORD_BITS-1:0] i_box_max_y,
    input  logic signed [COORD_BITS-1:0] i_box_max_z,
    input  logic [22:0]                  i_radius,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [5:0]                   o_found_id,
    output logic                         o_hit,
    output logic                         o_last
);
    import erqt_pkg::*;

    localparam int VALID_N = (MAX_ENTITIES < ID_SPAN) ? MAX_ENTITIES : ID_SPAN;
    localparam int AW      = $clog2(VALID_N);
    localparam int CW      = $clog2(VALID_N + 1);
    localparam int SUM_W   = 2 * COORD_BITS + 2;
    localparam logic [ID_W:0] ID_LIM  = (ID_W + 1)'(VALID_N);
    localparam logic [CW-1:0] SCAN_END = CW'(VALID_N);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } t_state;

    t_state r_state;

    t_op               op_in;
    logic              in_fire;
    logic              id_ok;
    logic [AW-1:0]     wid;
    logic              wr_en;
    logic              is_query;
    logic [RSQ_W-1:0]  rsq_in;
    logic              adv;
    logic              scan_fin;
    t_tok              iss_tok;
    logic [3*COORD_BITS-1:0] rd_data;

    t_tok              t4;
    logic [SUM_W-1:0]  d4;
    logic              m4;
    logic              is_near;
    logic              hit_evt;
    logic              hold_upd;
    logic              emit;
    logic [ID_W-1:0]   e_id;
    logic              e_hit;
    logic              e_last;

    logic [VALID_N-1:0]           r_valid;
    logic [CW-1:0]                r_scan;
    t_tok                         r_s1;
    t_op                          r_op;
    logic signed [COORD_BITS-1:0] r_px, r_py, r_pz, r_bx, r_by, r_bz;
    logic [RSQ_W-1:0]             r_rsq;
    logic                         r_hold_v;
    logic [ID_W-1:0]              r_hold_id;
    logic [SUM_W-1:0]             r_best_d;
    logic                         r_out_v;
    logic [ID_W-1:0]              r_out_id;
    logic                         r_out_hit;
    logic                         r_out_last;

    // input beat decode
    assign op_in    = t_op'(i_op);
    assign o_in_ready = (r_state == ST_IDLE);
    assign in_fire  = i_in_valid && o_in_ready;
    assign id_ok    = {1'b0, i_entity_id} < ID_LIM;
    assign wid      = AW'(i_entity_id);
    assign wr_en    = in_fire && id_ok &&
                      ((op_in == OP_INSERT) || ((op_in == OP_UPDATE) && r_valid[wid]));
    assign is_query = (op_in == OP_SPHERE) || (op_in == OP_BOX) || (op_in == OP_NEAREST);
    assign rsq_in   = i_radius * i_radius;

    // whole scan path moves only when the result register can take a beat
    assign adv      = !r_out_v || i_out_ready;
    assign scan_fin = (r_scan == SCAN_END);

    // scan beat issued alongside the RAM read
    always_comb begin
        iss_tok     = '0;
        iss_tok.v   = (r_state == ST_SCAN);
        iss_tok.fin = scan_fin;
        iss_tok.ok  = (r_state == ST_SCAN) && !scan_fin && r_valid[r_scan[AW-1:0]];
        iss_tok.id  = ID_W'(r_scan);
    end

    erqt_ram #(
        .WIDTH (3 * COORD_BITS),
        .DEPTH (VALID_N)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wid),
        .i_wdata ({i_pos_z, i_pos_y, i_pos_x}),
        .i_re    (adv && (r_state == ST_SCAN)),
        .i_raddr (r_scan[AW-1:0]),
        .o_rdata (rd_data)
    );

    erqt_pipe #(
        .COORD_BITS (COORD_BITS)
    ) u_pipe (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_tok     (r_s1),
        .i_rd_data (rd_data),
        .i_box     (r_op == OP_BOX),
        .i_px      (r_px),
        .i_py      (r_py),
        .i_pz      (r_pz),
        .i_bx      (r_bx),
        .i_by      (r_by),
        .i_bz      (r_bz),
        .i_rsq     (r_rsq),
        .o_tok     (t4),
        .o_dist    (d4),
        .o_match   (m4)
    );

    // result selection: one match is held back so the final one gets last
    assign is_near  = (r_op == OP_NEAREST);
    assign hit_evt  = t4.v && !t4.fin && t4.ok && m4;
    assign hold_upd = hit_evt && (!is_near || !r_hold_v || (d4 < r_best_d));

    always_comb begin
        emit   = 1'b0;
        e_id   = '0;
        e_hit  = 1'b0;
        e_last = 1'b0;
        if (t4.v && t4.fin) begin
            emit   = 1'b1;
            e_id   = r_hold_v ? r_hold_id : '0;
            e_hit  = r_hold_v;
            e_last = 1'b1;
        end else if (hit_evt && !is_near && r_hold_v) begin
            emit  = 1'b1;
            e_id  = r_hold_id;
            e_hit = 1'b1;
        end
    end

    // control state, slot flags and result handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_valid  <= '0;
            r_scan   <= '0;
            r_s1     <= '0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        if (wr_en) begin
                            r_valid[wid] <= 1'b1;
                        end
                        if ((op_in == OP_REMOVE) && id_ok) begin
                            r_valid[wid] <= 1'b0;
                        end
                        if (is_query) begin
                            r_state  <= ST_SCAN;
                            r_scan   <= '0;
                            r_hold_v <= 1'b0;
                        end
                    end
                end
                ST_SCAN: begin
                    if (adv) begin
                        r_scan <= r_scan + CW'(1);
                        if (scan_fin) begin
                            r_state <= ST_DRAIN;
                        end
                    end
                end
                ST_DRAIN: begin
                    if (adv && t4.v && t4.fin) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase

            if (adv) begin
                r_s1 <= iss_tok;
                if (hold_upd) begin
                    r_hold_v <= 1'b1;
                end
            end

            if (adv && emit) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // query operands, held match and result payload
    always_ff @(posedge i_clk) begin
        if (in_fire && is_query) begin
            r_op  <= op_in;
            r_px  <= i_pos_x;
            r_py  <= i_pos_y;
            r_pz  <= i_pos_z;
            r_bx  <= i_box_max_x;
            r_by  <= i_box_max_y;
            r_bz  <= i_box_max_z;
            r_rsq <= rsq_in;
        end
        if (adv && hold_upd) begin
            r_hold_id <= t4.id;
            r_best_d  <= d4;
        end
        if (adv && emit) begin
            r_out_id   <= e_id;
            r_out_hit  <= e_hit;
            r_out_last <= e_last;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_found_id  = r_out_id;
    assign o_hit       = r_out_hit;
    assign o_last      = r_out_last;

endmodule
`default_nettype wire

@@ hw/rtl/erqt_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module erqt_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data holds while read enable is low
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ hw/rtl/erqt_pipe.sv @@
// Compare pipeline: distance and box test of one table entry per beat.
`default_nettype none
module erqt_pipe #(
    parameter int COORD_BITS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  erqt_pkg::t_tok               i_tok,
    input  logic [3*COORD_BITS-1:0]      i_rd_data,
    input  logic                         i_box,
    input  logic signed [COORD_BITS-1:0] i_px,
    input  logic signed [COORD_BITS-1:0] i_py,
    input  logic signed [COORD_BITS-1:0] i_pz,
    input  logic signed [COORD_BITS-1:0] i_bx,
    input  logic signed [COORD_BITS-1:0] i_by,
    input  logic signed [COORD_BITS-1:0] i_bz,
    input  logic [erqt_pkg::RSQ_W-1:0]   i_rsq,
    output erqt_pkg::t_tok               o_tok,
    output logic [2*COORD_BITS+1:0]      o_dist,
    output logic                         o_match
);
    import erqt_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int SQ_W  = 2 * CB;
    localparam int SUM_W = 2 * CB + 2;
    localparam int CMP_W = (SUM_W > RSQ_W) ? SUM_W : RSQ_W;

    // |a - b| fits in CB bits for any two CB-bit signed values
    function automatic logic [CB-1:0] abs_diff(input logic signed [CB-1:0] a,
                                               input logic signed [CB-1:0] b);
        logic [CB:0] d;
        logic [CB:0] n;
        d = {a[CB-1], a} - {b[CB-1], b};
        n = -d;
        abs_diff = d[CB] ? n[CB-1:0] : d[CB-1:0];
    endfunction

    logic signed [CB-1:0] sx, sy, sz;
    logic                 box_in;
    logic [SUM_W-1:0]     sum;
    logic                 in_radius;

    t_tok             r_t2, r_t3, r_t4;
    logic [CB-1:0]    r_dx, r_dy, r_dz;
    logic             r_box2, r_box3;
    logic [SQ_W-1:0]  r_sqx, r_sqy, r_sqz;
    logic [SUM_W-1:0] r_dist;
    logic             r_match;

    // unpack the stored position
    assign sx = i_rd_data[CB-1:0];
    assign sy = i_rd_data[2*CB-1:CB];
    assign sz = i_rd_data[3*CB-1:2*CB];

    // inclusive box bounds; an inverted box matches nothing by itself
    assign box_in = (sx >= i_px) && (sx <= i_bx) &&
                    (sy >= i_py) && (sy <= i_by) &&
                    (sz >= i_pz) && (sz <= i_bz);

    // exact squared distance against squared radius
    assign sum       = SUM_W'(r_sqx) + SUM_W'(r_sqy) + SUM_W'(r_sqz);
    assign in_radius = CMP_W'(sum) <= CMP_W'(i_rsq);

    // beat tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t2 <= '0;
            r_t3 <= '0;
            r_t4 <= '0;
        end else if (i_adv) begin
            r_t2 <= i_tok;
            r_t3 <= r_t2;
            r_t4 <= r_t3;
        end
    end

    // datapath stages: differences, squares, sum and compare
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_dx    <= abs_diff(sx, i_px);
            r_dy    <= abs_diff(sy, i_py);
            r_dz    <= abs_diff(sz, i_pz);
            r_box2  <= box_in;
            r_sqx   <= r_dx * r_dx;
            r_sqy   <= r_dy * r_dy;
            r_sqz   <= r_dz * r_dz;
            r_box3  <= r_box2;
            r_dist  <= sum;
            r_match <= i_box ? r_box3 : in_radius;
        end
    end

    assign o_tok   = r_t4;
    assign o_dist  = r_dist;
    assign o_match = r_match;

endmodule
`default_nettype wire
